/* design/tbrl_pkg.sv */
// Shared types and constants for the token bucket rate limiter.
// No dependencies.
package tbrl_pkg;

    localparam int LEVEL_WIDTH_DEF = 64;
    localparam int RATE_W          = 20;
    localparam int TICK_W          = 32;
    localparam int LIMIT_W         = 52;
    localparam int REM_W           = 64;
    localparam int ADDR_W          = 4;

    localparam logic [ADDR_W-1:0] ADDR_RATE     = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_INTERVAL = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_WINDOW   = 4'h8;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TAKE = 1'b1;

    // Request word as it sits in the queue.
    typedef struct packed {
        logic              req_type;
        logic [TICK_W-1:0] elapsed_ticks;
        logic [TICK_W-1:0] take_count;
    } t_req;

    // Result word.
    typedef struct packed {
        logic                    granted;
        logic                    can_take;
        logic                    bucket_full;
        logic signed [REM_W-1:0] remaining_tokens;
    } t_rsp;

endpackage

/* design/tbrl_if.sv */
// Valid/ready channel carrying one word of type T.
// Depends on tbrl_pkg for the default word type.
interface tbrl_if #(
    parameter type T = tbrl_pkg::t_req
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/tbrl_front.sv */
// Front end: accepts request words into a two-entry queue.
// Depends on tbrl_pkg.
module tbrl_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tbrl_pkg::t_req i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output tbrl_pkg::t_req o_data
);
    tbrl_pkg::t_req r_q [2];
    logic [1:0]     r_cnt;
    logic           r_rd, r_wr;
    logic           w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Hold the payload words.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_data;
        end
    end

    // Advance pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !w_pop) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !w_push) else $error("push into full queue");
endmodule

/* design/tbrl_div.sv */
// Restoring divider: signed dividend by unsigned 32-bit divisor, one bit a cycle.
// Depends on tbrl_pkg.
module tbrl_div #(
    parameter int LW = tbrl_pkg::LEVEL_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [LW-1:0]          i_num,
    input  logic [tbrl_pkg::TICK_W-1:0]   i_den,
    output logic                          o_done,
    output logic signed [LW-1:0]          o_quo
);
    localparam int CW = $clog2(LW + 1);
    localparam int RW = tbrl_pkg::TICK_W + 1;

    logic [LW-1:0] r_q;
    logic [RW-1:0] r_r;
    logic [tbrl_pkg::TICK_W-1:0] r_d;
    logic          r_neg, r_busy;
    logic [CW-1:0] r_cnt;
    logic [RW-1:0] w_sh, w_sub;
    logic [LW-1:0] w_mag;

    assign w_mag = i_num[LW-1] ? (~i_num + 1'b1) : i_num;
    assign w_sh  = {r_r[RW-2:0], r_q[LW-1]};
    assign w_sub = w_sh - {1'b0, r_d};
    assign o_quo = r_neg ? $signed(~r_q + 1'b1) : $signed(r_q);

    // Step one quotient bit a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_q    <= w_mag;
                r_r    <= '0;
                r_d    <= (i_den == '0) ? 32'd1 : i_den;
                r_neg  <= i_num[LW-1];
                r_cnt  <= CW'(LW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!w_sub[RW-1]) begin
                    r_r <= w_sub;
                    r_q <= {r_q[LW-2:0], 1'b1};
                end else begin
                    r_r <= w_sh;
                    r_q <= {r_q[LW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

/* design/tbrl_back.sv */
// Back end: applies a request to the bucket, then divides for whole tokens.
// Depends on tbrl_pkg and tbrl_div.
module tbrl_back #(
    parameter int LW = tbrl_pkg::LEVEL_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  tbrl_pkg::t_req              i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output tbrl_pkg::t_rsp              o_data,
    input  logic                        i_refill,
    input  logic [tbrl_pkg::RATE_W-1:0] i_rate,
    input  logic [tbrl_pkg::TICK_W-1:0] i_interval,
    input  logic [tbrl_pkg::TICK_W-1:0] i_window
);
    localparam int PW = tbrl_pkg::RATE_W + tbrl_pkg::TICK_W;   // 52
    // Wide enough for a full level minus a 64-bit cost, for level widths up to 65 bits.
    localparam int EW = tbrl_pkg::REM_W + 2;
    localparam logic signed [LW-1:0] LMAX = {1'b0, {(LW-1){1'b1}}};
    localparam logic signed [LW-1:0] LMIN = {1'b1, {(LW-1){1'b0}}};

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_UPD, S_DIV, S_OUT} t_state;

    t_state r_state;
    tbrl_pkg::t_req r_req;
    logic [PW-1:0] r_limit, r_prod;
    logic [63:0]   r_cost;
    logic signed [LW-1:0] r_level;
    logic          r_granted;
    logic          r_div_go;
    logic          w_done;
    logic signed [LW-1:0] w_quo;
    logic [PW-1:0] w_lprod;
    logic signed [LW-1:0] w_cap;
    logic signed [EW-1:0] w_sum, w_diff;
    logic [tbrl_pkg::TICK_W-1:0] w_ieff;

    assign w_ieff  = (i_interval == '0) ? 32'd1 : i_interval;
    assign w_lprod = PW'(i_rate) * PW'(i_window);
    assign w_cap   = ({{(EW-PW){1'b0}}, r_limit} > EW'(LMAX)) ? LMAX : LW'(r_limit);
    assign w_sum   = EW'(r_level) + $signed({{(EW-PW){1'b0}}, r_prod});
    assign w_diff  = EW'(r_level) - $signed({{(EW-64){1'b0}}, r_cost});
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    tbrl_div #(.LW(LW)) u_div (
        .i_clk, .i_rst_n, .i_start(r_div_go), .i_num(r_level),
        .i_den(i_interval), .o_done(w_done), .o_quo(w_quo)
    );

    // Sequence one request through multiply, update, divide and output; a refill reloads limit and level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_limit  <= '0;
            r_level  <= '0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (i_refill) begin
                r_limit <= w_lprod;
                r_level <= ({{(EW-PW){1'b0}}, w_lprod} > EW'(LMAX)) ? LMAX : LW'(w_lprod);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req   <= i_data;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PW'(i_rate) * PW'(r_req.elapsed_ticks);
                    r_cost  <= 64'(r_req.take_count) * 64'(w_ieff);
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    // Refuse a take while the bucket is in deficit.
                    r_granted <= !((r_req.req_type == tbrl_pkg::REQ_TAKE) && r_level[LW-1]);
                    if (r_req.req_type == tbrl_pkg::REQ_ADD) begin
                        r_level <= (w_sum > EW'(w_cap)) ? w_cap : LW'(w_sum);
                    end else if (!r_level[LW-1]) begin
                        r_level <= (w_diff < EW'(LMIN)) ? LMIN : LW'(w_diff);
                    end
                    r_div_go <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (w_done) begin
                        o_data.granted          <= r_granted;
                        o_data.can_take         <= !r_level[LW-1];
                        o_data.bucket_full      <= !r_level[LW-1] &&
                            ({{(EW-LW){1'b0}}, r_level} == {{(EW-PW){1'b0}}, r_limit});
                        o_data.remaining_tokens <= 64'(w_quo);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_level_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_req.req_type == tbrl_pkg::REQ_ADD) |-> (r_level <= w_cap))
        else $error("level above cap after add");
    a_refuse_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_req.req_type == tbrl_pkg::REQ_TAKE && r_level[LW-1]
         && !i_refill) |=> $stable(r_level)) else $error("refused take changed level");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
endmodule

/* design/token_bucket_rate_limiter_core.sv */
// Token bucket rate limiter top level: front queue, bucket back end, APB registers.
// Each word passes multiply, update, divide and output; the divider is bit-serial.
// The back end holds one word and takes no new one until its result is taken.
// Reset (synchronous, active low): rate 0, interval 1, window 0, level and limit 0.
// Depends on tbrl_pkg, tbrl_if, tbrl_front, tbrl_back.
module token_bucket_rate_limiter_core #(
    parameter int LEVEL_WIDTH = tbrl_pkg::LEVEL_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tbrl_if.sink                        i_req,
    tbrl_if.source                      o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tbrl_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    logic [tbrl_pkg::RATE_W-1:0] r_rate;
    logic [tbrl_pkg::TICK_W-1:0] r_interval, r_window;
    logic           r_refill;
    logic           w_wr, q_valid, q_ready;
    tbrl_pkg::t_req q_data;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Decode register writes; any known write refills the bucket next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate     <= '0;
            r_interval <= 32'd1;
            r_window   <= '0;
            r_refill   <= 1'b0;
        end else begin
            r_refill <= 1'b0;
            if (w_wr) begin
                unique case (paddr)
                    tbrl_pkg::ADDR_RATE: begin
                        r_rate <= pwdata[tbrl_pkg::RATE_W-1:0]; r_refill <= 1'b1;
                    end
                    tbrl_pkg::ADDR_INTERVAL: begin
                        r_interval <= pwdata; r_refill <= 1'b1;
                    end
                    tbrl_pkg::ADDR_WINDOW: begin
                        r_window <= pwdata; r_refill <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Return register contents.
    always_comb begin
        case (paddr)
            tbrl_pkg::ADDR_RATE:     prdata = {12'd0, r_rate};
            tbrl_pkg::ADDR_INTERVAL: prdata = r_interval;
            tbrl_pkg::ADDR_WINDOW:   prdata = r_window;
            default:                 prdata = '0;
        endcase
    end

    tbrl_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_req.valid), .o_ready(i_req.ready), .i_data(i_req.data),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_data)
    );

    tbrl_back #(.LW(LEVEL_WIDTH)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_data(q_data),
        .o_valid(o_rsp.valid), .i_ready(o_rsp.ready), .o_data(o_rsp.data),
        .i_refill(r_refill), .i_rate(r_rate), .i_interval(r_interval),
        .i_window(r_window)
    );
endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the token bucket rate limiter core.
// Depends on tbrl_pkg, tbrl_if and token_bucket_rate_limiter_core.
`timescale 1ns / 1ps

module tb_top;

    localparam int LAT = 80;
    localparam int WATCH_LIMIT = 4000;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [tbrl_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    tbrl_if #(.T(tbrl_pkg::t_req)) req_ch ();
    tbrl_if #(.T(tbrl_pkg::t_rsp)) rsp_ch ();

    token_bucket_rate_limiter_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state
    logic [tbrl_pkg::RATE_W-1:0] m_rate;
    logic [tbrl_pkg::TICK_W-1:0] m_interval, m_window;
    logic signed [63:0] m_level;
    logic [63:0] m_limit;

    tbrl_pkg::t_rsp expected_rsps[$];
    int errors;
    int idle_cycles;
    bit hold_sink;
    int sink_hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    function automatic logic signed [63:0] cap_of();
        if (m_limit > 64'h7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        return $signed(m_limit);
    endfunction

    function automatic void bucket_refill();
        m_limit = 64'(m_rate) * 64'(m_window);
        m_level = cap_of();
    endfunction

    // Advance the bucket by one request and return the status word
    function automatic tbrl_pkg::t_rsp bucket_update(input tbrl_pkg::t_req r);
        tbrl_pkg::t_rsp o;
        logic signed [63:0] earn, cap;
        logic [63:0] cost, room, iv;
        iv = (m_interval == 0) ? 64'd1 : 64'(m_interval);
        o.granted = 1'b1;
        if (r.req_type == tbrl_pkg::REQ_ADD) begin
            earn = $signed(64'(m_rate) * 64'(r.elapsed_ticks));
            cap = cap_of();
            if (m_level > cap - earn) m_level = cap;
            else m_level = m_level + earn;
        end else if (m_level < 0) begin
            o.granted = 1'b0;
        end else begin
            cost = 64'(r.take_count) * iv;
            room = 64'(m_level) + 64'h8000_0000_0000_0000;
            if (cost >= room) m_level = 64'sh8000_0000_0000_0000;
            else m_level = $signed(64'(m_level) - cost);
        end
        o.can_take = (m_level >= 0);
        o.bucket_full = (m_level >= 0) && (64'(m_level) == m_limit);
        o.remaining_tokens = m_level / $signed(iv);
        return o;
    endfunction

    // Drop the request, wait for the block to drain, then let the back end settle
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (expected_rsps.size() != 0) @(negedge i_clk);
        repeat (LAT) @(negedge i_clk);
    endtask

    // Register write: setup then access phase, then back to idle
    task automatic reg_write(input logic [tbrl_pkg::ADDR_W-1:0] a, input logic [31:0] d);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge i_clk);
        if (a == tbrl_pkg::ADDR_RATE) m_rate = d[tbrl_pkg::RATE_W-1:0];
        else if (a == tbrl_pkg::ADDR_INTERVAL) m_interval = d;
        else if (a == tbrl_pkg::ADDR_WINDOW) m_window = d;
        else return;
        bucket_refill();
    endtask

    task automatic set_bucket(input logic [31:0] rate, input logic [31:0] iv,
                              input logic [31:0] win);
        wait_idle();
        reg_write(tbrl_pkg::ADDR_RATE, rate);
        reg_write(tbrl_pkg::ADDR_INTERVAL, iv);
        reg_write(tbrl_pkg::ADDR_WINDOW, win);
    endtask

    // Offer one word, hold until accepted; valid stays up for a following word
    task automatic send_word(input tbrl_pkg::t_req r, input bit gaps);
        int n;
        n = gaps ? int'($urandom_range(0, 7)) : 0;
        if (n != 0) begin
            req_ch.valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        expected_rsps.push_back(bucket_update(r));
        @(negedge i_clk);
    endtask

    function automatic tbrl_pkg::t_req make_req(input logic kind, input logic [31:0] e,
                                                input logic [31:0] t);
        tbrl_pkg::t_req r;
        r.req_type = kind; r.elapsed_ticks = e; r.take_count = t;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 8);
            1: return $urandom_range(0, 1000);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // Check each result word against the oldest prediction
    initial begin
        tbrl_pkg::t_rsp got, want;
        int n;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                rsp_ch.ready <= 1'b0;
                repeat (sink_hold_cycles) @(negedge i_clk);
                hold_sink = 1'b0;
            end
            n = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 7)) : 0;
            if (n != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            got = rsp_ch.data;
            if (expected_rsps.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                want = expected_rsps.pop_front();
                if (got.granted !== want.granted)
                    report($sformatf("granted %b want %b", got.granted, want.granted));
                if (got.can_take !== want.can_take)
                    report($sformatf("can_take %b want %b", got.can_take, want.can_take));
                if (got.bucket_full !== want.bucket_full)
                    report($sformatf("bucket_full %b want %b",
                                     got.bucket_full, want.bucket_full));
                if (got.remaining_tokens !== want.remaining_tokens)
                    report($sformatf("remaining %0d want %0d",
                                     got.remaining_tokens, want.remaining_tokens));
            end
        end
    end

    // Watchdog: count cycles without any accepted word
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic test_directed();
        set_bucket(32'd10, 32'd1, 32'd100);
        send_word(make_req(tbrl_pkg::REQ_TAKE, 0, 32'd5), 1);
        send_word(make_req(tbrl_pkg::REQ_ADD, 32'd3, 0), 1);
        send_word(make_req(tbrl_pkg::REQ_ADD, 32'hFFFF_FFFF, 0), 1);
        send_word(make_req(tbrl_pkg::REQ_TAKE, 0, 32'd2000), 1);
        send_word(make_req(tbrl_pkg::REQ_TAKE, 0, 32'd1), 1);
        send_word(make_req(tbrl_pkg::REQ_ADD, 32'd0, 0), 1);
        send_word(make_req(tbrl_pkg::REQ_TAKE, 0, 32'd0), 1);
        // zero interval behaves as one
        set_bucket(32'd7, 32'd0, 32'd9);
        send_word(make_req(tbrl_pkg::REQ_TAKE, 0, 32'd60), 1);
        send_word(make_req(tbrl_pkg::REQ_TAKE, 0, 32'd1), 1);
        // extremes: widest limit, deep deficit
        set_bucket(32'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(make_req(tbrl_pkg::REQ_TAKE, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1);
        send_word(make_req(tbrl_pkg::REQ_TAKE, 0, 32'hFFFF_FFFF), 1);
        send_word(make_req(tbrl_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1);
        send_word(make_req(tbrl_pkg::REQ_TAKE, 0, 32'hFFFF_FFFF), 1);
        send_word(make_req(tbrl_pkg::REQ_TAKE, 0, 32'hFFFF_FFFF), 1);
        send_word(make_req(tbrl_pkg::REQ_TAKE, 0, 32'hFFFF_FFFF), 1);
        send_word(make_req(tbrl_pkg::REQ_ADD, 32'hFFFF_FFFF, 0), 1);
        // unknown register address is ignored
        wait_idle();
        reg_write(4'hC, 32'hDEAD_BEEF);
        send_word(make_req(tbrl_pkg::REQ_TAKE, 0, 32'd3), 1);
        set_bucket(32'd0, 32'd1, 32'd0);
        send_word(make_req(tbrl_pkg::REQ_TAKE, 0, 32'd1), 1);
        send_word(make_req(tbrl_pkg::REQ_ADD, 32'd5, 0), 1);
    endtask

    task automatic test_random_traffic(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 0)
                set_bucket($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 50),
                           $urandom_range(0, 3) == 0 ? rand_word() : $urandom_range(1, 20),
                           rand_word());
            send_word(make_req(1'($urandom_range(0, 1)), rand_word(), rand_word()),
                      $urandom_range(0, 4) != 0);
        end
    endtask

    // Stall the receiver long enough for the block to back up
    task automatic test_backpressure();
        wait_idle();
        sink_hold_cycles = 400;
        hold_sink = 1'b1;
        for (int i = 0; i < 20; i++)
            send_word(make_req(1'($urandom_range(0, 1)), rand_word(),
                               $urandom_range(0, 9)), 0);
        // hold the sender until everything has drained
        req_ch.valid <= 1'b0;
        while (expected_rsps.size() != 0) @(negedge i_clk);
        for (int i = 0; i < 10; i++)
            send_word(make_req(1'($urandom_range(0, 1)), rand_word(), rand_word()), 0);
    endtask

    initial begin
        errors = 0;
        hold_sink = 1'b0;
        sink_hold_cycles = 0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        m_rate = '0; m_interval = 32'd1; m_window = '0; m_level = '0; m_limit = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_backpressure();
        test_random_traffic(470);

        wait_idle();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
